@@ rtl/core/teb_pkg.sv @@
// Shared types and constants of the time-to-collision emergency brake block.
`timescale 1ns / 1ps

package teb_pkg;

  // Register index width on the configuration channel
  localparam int CFG_IDX_W = 2;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TTC_THRESHOLD = 2'd0,
    REG_START_ANGLE   = 2'd1,
    REG_ANGLE_STEP    = 2'd2
  } cfg_reg_t;

  // TTC saturation, 100 s in Q8.8, and the threshold reset of 0.4 s
  localparam logic [14:0] TTC_SAT      = 15'd25600;
  localparam logic [15:0] THRESH_RESET = 16'd102;

  // Restoring divider: a 24-bit dividend (range << 8), one quotient bit a step
  localparam int DIV_STEPS = 24;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // input request taken this cycle
    logic rom_rd;    // read the cosine ROM at the current beam angle
    logic mult;      // project the speed onto the beam
    logic check;     // test the projection and load the divider
    logic div_step;  // one divider iteration
    logic update;    // fold TTC into the minimum, advance the angle
    logic emit;      // load the result register
  } teb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_beam;   // pending input request is a lidar beam
    logic approach;  // projected speed is positive and non-zero
    logic div_last;  // final divider iteration
    logic scan_end;  // current beam closes the scan
    logic out_free;  // result register can take a new result
  } teb_sts_t;

endpackage

@@ rtl/core/teb_ifs.sv @@
// Channel interfaces of the emergency brake block: input, result and configuration.
`timescale 1ns / 1ps

interface teb_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] vehicle_speed;
  logic        [15:0] beam_range;
  logic               scan_end;

  modport source (output valid, req_type, vehicle_speed, beam_range, scan_end,
                  input ready);
  modport sink   (input valid, req_type, vehicle_speed, beam_range, scan_end,
                  output ready);
endinterface

interface teb_out_if;
  logic        valid;
  logic        ready;
  logic        brake;
  logic [14:0] least_ttc;

  modport source (output valid, brake, least_ttc, input ready);
  modport sink   (input valid, brake, least_ttc, output ready);
endinterface

interface teb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/teb_ctrl.sv @@
// Sequencing state machine of the emergency brake block.
`timescale 1ns / 1ps

module teb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  teb_pkg::teb_sts_t sts,
  output teb_pkg::teb_cmd_t cmd
);
  import teb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOKUP = 7'b0000010,
    S_MULT   = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Requests are only taken between beams
  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.in_beam) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.rom_rd = 1'b1;
        state_nxt  = S_MULT;
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.approach ? S_DIV : S_UPDATE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.scan_end ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold the result until the output register is free
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output register occupied");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.rom_rd || cmd.mult || cmd.check || cmd.div_step ||
                   cmd.update || cmd.emit))
    else $error("input ready while a beam is in progress");

  a_beam_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.in_beam) |=> cmd.rom_rd)
    else $error("accepted beam not followed by ROM read");

endmodule

@@ rtl/core/teb_dp.sv @@
// Datapath of the emergency brake block: registers, cosine ROM, projection, divider.
`timescale 1ns / 1ps

module teb_dp #(
  parameter int COS_TABLE_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  teb_in_if.sink            in_ch,
  teb_out_if.source         out_ch,
  teb_cfg_if.sink           cfg_ch,
  input  teb_pkg::teb_cmd_t cmd,
  output teb_pkg::teb_sts_t sts
);
  import teb_pkg::*;

  localparam int IDX_W = $clog2(COS_TABLE_ENTRIES);
  localparam int SCL_W = 16 + IDX_W + 1;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef logic signed [15:0] cos_rom_t [COS_TABLE_ENTRIES];

  // cos over the first quadrant, Taylor series to x^16 in Q30
  function automatic logic [63:0] cos_quarter_q30(input logic [63:0] x);
    logic [63:0] rad;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int          n;
    rad  = (x * PI_Q30) >> 15;
    x2   = (rad * rad) >> 30;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 2;
        2:       term = term / 12;
        3:       term = term / 30;
        4:       term = term / 56;
        5:       term = term / 90;
        6:       term = term / 132;
        7:       term = term / 182;
        default: term = term / 240;
      endcase
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum);
  endfunction

  // Fold a full-turn angle into the first quadrant, round to Q1.14
  function automatic logic signed [15:0] cos_q14(input logic [63:0] a_in);
    logic [63:0]        a;
    logic [63:0]        v;
    logic               neg;
    logic signed [15:0] v16;
    a   = a_in & 64'hFFFF;
    neg = 1'b0;
    if (a > 64'd32768) a = 64'd65536 - a;
    if (a > 64'd16384) begin
      a   = 64'd32768 - a;
      neg = 1'b1;
    end
    v = (cos_quarter_q30(a) + 64'd32768) >> 16;
    if (v > 64'd16384) v = 64'd16384;
    v16 = 16'(v);
    return neg ? 16'(-v16) : v16;
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    int       k;
    for (k = 0; k < COS_TABLE_ENTRIES; k++) begin
      rom[k] = cos_q14(64'((longint'(k) * 65536) / COS_TABLE_ENTRIES));
    end
    return rom;
  endfunction

  localparam cos_rom_t CosRom = build_cos_rom();

  // Configuration registers
  logic [15:0] ttc_thr_r, start_angle_r, angle_step_r;

  // Scan state
  logic signed [15:0] speed_r;
  logic        [14:0] min_r;
  logic        [15:0] angle_r;
  logic               in_scan_r;

  // Per-beam working registers
  logic        [15:0] range_r;
  logic               scan_end_r;
  logic signed [15:0] cos_r;
  logic signed [31:0] prod_r;
  logic               approached_r;
  logic        [15:0] div_r;
  logic        [15:0] rem_r;
  logic        [23:0] quo_r;
  logic   [CNT_W-1:0] cnt_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_brake_r;
  logic [14:0] out_ttc_r;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttc_thr_r     <= THRESH_RESET;
      start_angle_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_TTC_THRESHOLD: ttc_thr_r     <= cfg_ch.data;
        REG_START_ANGLE:   start_angle_r <= cfg_ch.data;
        REG_ANGLE_STEP:    angle_step_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ROM address: angle scaled to the table depth
  logic [SCL_W-1:0] angle_scaled;
  logic [IDX_W-1:0] rom_idx;
  assign angle_scaled = SCL_W'(angle_r) * SCL_W'(COS_TABLE_ENTRIES);
  assign rom_idx      = angle_scaled[16+IDX_W-1:16];

  always_ff @(posedge clk) begin
    if (cmd.rom_rd) cos_r <= CosRom[rom_idx];
  end

  // Projection test: positive product whose Q8.8 value is non-zero
  logic [15:0] proj;
  logic        approach;
  assign proj     = prod_r[29:14];
  assign approach = !prod_r[31] && (prod_r != '0) && (proj != '0);

  // Divider step
  logic [16:0] rem_sh, rem_diff;
  logic        rem_ge;
  assign rem_sh   = {rem_r, quo_r[23]};
  assign rem_ge   = rem_sh >= {1'b0, div_r};
  assign rem_diff = rem_sh - {1'b0, div_r};

  // Saturated TTC of this beam
  logic [14:0] ttc_sat;
  assign ttc_sat = (quo_r > 24'(TTC_SAT)) ? TTC_SAT : quo_r[14:0];

  // Beam working registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_ch.req_type) begin
      range_r    <= in_ch.beam_range;
      scan_end_r <= in_ch.scan_end;
    end
    if (cmd.mult) prod_r <= speed_r * cos_r;
    if (cmd.check) begin
      approached_r <= approach;
      div_r        <= proj;
      rem_r        <= '0;
      quo_r        <= {range_r, 8'd0};
      cnt_r        <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[22:0], rem_ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Scan state: speed, running minimum, beam angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      min_r     <= TTC_SAT;
      angle_r   <= '0;
      in_scan_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (!in_ch.req_type) begin
          speed_r <= in_ch.vehicle_speed;
        end else if (!in_scan_r) begin
          // first beam of a scan
          angle_r   <= start_angle_r;
          min_r     <= TTC_SAT;
          in_scan_r <= 1'b1;
        end
      end
      if (cmd.update) begin
        if (approached_r && (ttc_sat < min_r)) min_r <= ttc_sat;
        angle_r <= angle_r + angle_step_r;
      end
      if (cmd.emit) in_scan_r <= 1'b0;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (cmd.emit)     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_brake_r <= ({1'b0, min_r} < ttc_thr_r) && (speed_r > 16'sd0);
      out_ttc_r   <= min_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.brake     = out_brake_r;
  assign out_ch.least_ttc = out_ttc_r;

  // Status to the controller
  assign sts.in_beam  = in_ch.req_type;
  assign sts.approach = approach;
  assign sts.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sts.scan_end = scan_end_r;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // Checks
  a_min_sat: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= TTC_SAT)
    else $error("running minimum above saturation");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < div_r)
    else $error("divider remainder not below divisor");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && (out_ttc_r <= TTC_SAT))
    else $error("emitted result missing or out of range");

endmodule

@@ rtl/core/ttc_emergency_brake.sv @@
// Top level of the time-to-collision emergency brake block.
//
// in_ch takes requests: req_type 0 stores vehicle_speed (signed Q8.8 m/s),
// req_type 1 is a lidar beam with beam_range (Q8.8 m) and scan_end.
// out_ch gives one result per scan, on the beam with scan_end set: least_ttc
// (Q8.8 s, saturated at 100 s) and brake. cfg_ch writes ttc_threshold,
// start_angle and angle_step by index; it is always ready.
// A speed update is taken in the idle state. A beam that is not approaching
// passes lookup, multiply, check and update; an approaching beam also runs
// the 24-step radix-2 divider that forms range / projected speed. The closing
// beam then loads the result register, whose output is valid in the cycle after.
// Reset (rst_n low, synchronous) sets threshold to 0.4 s, angles and speed to
// zero, and clears any scan and pending result.
// A stalled receiver holds the result; requests are still taken until the next
// closing beam, which waits for the result register to drain.
`timescale 1ns / 1ps

module ttc_emergency_brake #(
  parameter int COS_TABLE_ENTRIES = 1024
) (
  input logic       clk,
  input logic       rst_n,
  teb_in_if.sink    in_ch,
  teb_out_if.source out_ch,
  teb_cfg_if.sink   cfg_ch
);
  import teb_pkg::*;

  teb_cmd_t cmd;
  teb_sts_t sts;

  // Sequencer owns the input handshake
  teb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath owns the payload, configuration and result register
  teb_dp #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
